FILE: rtl/slhw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sensor link health watchdog.
// No dependencies; used by slhw_cmp_unit and sensor_link_health_watchdog.

package slhw_pkg;

    // Default channel count and mask width
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int MASK_BITS        = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_TIMEOUT_US   = 2'd0;
    localparam logic [1:0] REG_STREAM_COUNT = 2'd1;
    localparam logic [1:0] REG_CHECK_MASK   = 2'd2;
    localparam logic [1:0] REG_PRESENT_MASK = 2'd3;

    // Register reset values
    localparam logic [31:0] TIMEOUT_US_RST   = 32'd200000;
    localparam logic [15:0] STREAM_COUNT_RST = 16'd10;
    localparam logic [15:0] CHECK_MASK_RST   = 16'hFFFF;
    localparam logic [15:0] PRESENT_MASK_RST = 16'h0000;

    // Channel health codes
    typedef logic [1:0] t_health;
    localparam t_health HEALTH_UNKNOWN = 2'd0;
    localparam t_health HEALTH_TIMEOUT = 2'd1;
    localparam t_health HEALTH_OK      = 2'd2;

    // One channel entry of the arrival store
    typedef struct packed {
        logic [31:0] last;
        logic [15:0] cnt;
    } t_entry;

    // Operands of the shared subtract-and-compare unit
    typedef struct packed {
        logic [31:0] minuend;
        logic [31:0] subtrahend;
        logic [31:0] limit;
    } t_cmp_req;

endpackage

FILE: rtl/sensor_link_health_watchdog.sv
`timescale 1ns / 1ps
// Top level of the sensor link health watchdog: sequencer, channel store and health flags.
// Depends on slhw_pkg and slhw_cmp_unit.
//
// Use: one input channel (i_in_valid / o_in_stall) carries commands: an arrival on
// i_channel or a tick (i_cmd high) that checks every enabled channel at i_time_now.
// Every command gives one result beat on the output channel (o_out_valid /
// i_out_stall): o_connected, o_timed_out_mask and o_health_ok.
// Registers are written through i_cfg_valid / o_cfg_ready with i_cfg_index and
// i_cfg_data; the port is always ready. The user must write them only while the block
// is idle; the block itself does not enforce it.
// Timing: the block takes one command at a time and stalls its input meanwhile.
// An arrival passes through the read, update and output states, then returns to idle.
// A tick walks min(NUM_CHANNELS, 16) entries through the single subtract-and-compare
// unit, one per cycle, checks the last entry, then loads its result in the output state.
// The single unit and the registered read of the store set this walk.
// A new command is taken while the last result still waits; if the receiver
// stalls, the sequencer holds its finished result until the output register frees.
// Reset: registers return to their defaults, every channel goes to unknown and
// its count and last arrival time read as zero; no clearing pass is needed.

module sensor_link_health_watchdog #(
    parameter int NUM_CHANNELS = slhw_pkg::NUM_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [3:0]  i_channel,
    input  logic [31:0] i_time_now,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_connected,
    output logic [15:0] o_timed_out_mask,
    output logic        o_health_ok,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int WALK_N = (NUM_CHANNELS < slhw_pkg::MASK_BITS) ? NUM_CHANNELS
                                                                 : slhw_pkg::MASK_BITS;
    localparam logic [IDX_W-1:0] WALK_LAST = IDX_W'(WALK_N - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ARD   = 3'd1;
    localparam logic [2:0] S_AEV   = 3'd2;
    localparam logic [2:0] S_TWALK = 3'd3;
    localparam logic [2:0] S_TLAST = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // Configuration registers
    logic [31:0] r_timeout_us;
    logic [15:0] r_stream_count;
    logic [15:0] r_check_mask;
    logic [15:0] r_present_mask;

    // Sequencer and item registers
    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [31:0]      r_now, n_now;
    logic [IDX_W-1:0] r_walk, n_walk;
    logic             r_ev_vld, n_ev_vld;
    logic [IDX_W-1:0] r_ev_idx, n_ev_idx;
    logic [15:0]      r_drop, n_drop;
    logic             r_conn, n_conn;

    // Channel store and health flags
    slhw_pkg::t_entry  r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_mem_vld;
    slhw_pkg::t_entry  r_rd_data;
    logic              r_rd_vld;
    slhw_pkg::t_health r_health [NUM_CHANNELS];

    // Output register
    logic        r_out_valid;
    logic        r_out_conn;
    logic [15:0] r_out_mask;
    logic        r_out_hok;

    // Store and health port controls
    logic              mem_re;
    logic [IDX_W-1:0]  mem_ra;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    slhw_pkg::t_entry  mem_wd;
    logic              hw_en;
    logic [IDX_W-1:0]  hw_idx;
    slhw_pkg::t_health hw_val;
    logic              out_load;

    // Datapath signals
    slhw_pkg::t_entry   rd_entry;
    logic [15:0]        cnt_inc;
    slhw_pkg::t_cmp_req cmp_req;
    logic               cmp_gt;
    logic [NUM_CHANNELS-1:0] chk_vec;
    logic [NUM_CHANNELS-1:0] prs_vec;
    logic [NUM_CHANNELS-1:0] bad_vec;
    logic                    health_all;
    logic                    in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;

    // Write configuration registers; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_us   <= slhw_pkg::TIMEOUT_US_RST;
            r_stream_count <= slhw_pkg::STREAM_COUNT_RST;
            r_check_mask   <= slhw_pkg::CHECK_MASK_RST;
            r_present_mask <= slhw_pkg::PRESENT_MASK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                slhw_pkg::REG_TIMEOUT_US:   r_timeout_us   <= i_cfg_data;
                slhw_pkg::REG_STREAM_COUNT: r_stream_count <= i_cfg_data[15:0];
                slhw_pkg::REG_CHECK_MASK:   r_check_mask   <= i_cfg_data[15:0];
                slhw_pkg::REG_PRESENT_MASK: r_present_mask <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Spread the masks over the channels; channels past the mask width get none
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_mask
        if (g < slhw_pkg::MASK_BITS) begin : g_in
            assign chk_vec[g] = r_check_mask[g];
            assign prs_vec[g] = r_present_mask[g];
        end else begin : g_out
            assign chk_vec[g] = 1'b0;
            assign prs_vec[g] = 1'b0;
        end
        assign bad_vec[g] = prs_vec[g] && (r_health[g] != slhw_pkg::HEALTH_OK);
    end

    assign health_all = ~|bad_vec;

    // Entries never written read as zero
    assign rd_entry = r_rd_vld ? r_rd_data : '0;
    assign cnt_inc  = (rd_entry.cnt == 16'hFFFF) ? rd_entry.cnt : rd_entry.cnt + 16'd1;

    // Feed the shared unit: count test on arrivals, age test on ticks
    always_comb begin
        if (r_state == S_AEV) begin
            cmp_req.minuend    = 32'(cnt_inc);
            cmp_req.subtrahend = 32'd0;
            cmp_req.limit      = 32'(r_stream_count);
        end else begin
            cmp_req.minuend    = r_now;
            cmp_req.subtrahend = rd_entry.last;
            cmp_req.limit      = r_timeout_us;
        end
    end

    slhw_cmp_unit u_cmp (
        .i_req (cmp_req),
        .o_gt  (cmp_gt)
    );

    // Sequence arrivals and the tick walk
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_now    = r_now;
        n_walk   = r_walk;
        n_ev_vld = r_ev_vld;
        n_ev_idx = r_ev_idx;
        n_drop   = r_drop;
        n_conn   = r_conn;
        mem_re   = 1'b0;
        mem_ra   = r_idx;
        mem_we   = 1'b0;
        mem_wa   = r_idx;
        mem_wd   = '0;
        hw_en    = 1'b0;
        hw_idx   = r_idx;
        hw_val   = slhw_pkg::HEALTH_UNKNOWN;
        out_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_idx    = IDX_W'(i_channel);
                    n_now    = i_time_now;
                    n_walk   = '0;
                    n_ev_vld = 1'b0;
                    n_drop   = '0;
                    n_conn   = 1'b0;
                    if (i_cmd) begin
                        n_state = S_TWALK;
                    end else if (32'(i_channel) < 32'(NUM_CHANNELS)) begin
                        n_state = S_ARD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_ARD: begin
                mem_re  = 1'b1;
                mem_ra  = r_idx;
                n_state = S_AEV;
            end
            S_AEV: begin
                // stamp time, bump count, advance health
                mem_we      = 1'b1;
                mem_wa      = r_idx;
                mem_wd.last = r_now;
                mem_wd.cnt  = cnt_inc;
                hw_idx      = r_idx;
                if (r_health[r_idx] == slhw_pkg::HEALTH_TIMEOUT && cmp_gt) begin
                    hw_en  = 1'b1;
                    hw_val = slhw_pkg::HEALTH_OK;
                    n_conn = 1'b1;
                end else if (r_health[r_idx] == slhw_pkg::HEALTH_UNKNOWN) begin
                    hw_en  = 1'b1;
                    hw_val = slhw_pkg::HEALTH_TIMEOUT;
                end
                n_state = S_OUT;
            end
            S_TWALK, S_TLAST: begin
                // issue the next read while the previous entry is checked
                if (r_state == S_TWALK) begin
                    mem_re   = 1'b1;
                    mem_ra   = r_walk;
                    n_ev_idx = r_walk;
                    n_ev_vld = 1'b1;
                    if (r_walk == WALK_LAST) begin
                        n_state = S_TLAST;
                    end else begin
                        n_walk = r_walk + IDX_W'(1);
                    end
                end else begin
                    n_state = S_OUT;
                end
                if (r_ev_vld && chk_vec[r_ev_idx] &&
                    r_health[r_ev_idx] == slhw_pkg::HEALTH_OK && cmp_gt) begin
                    mem_we      = 1'b1;
                    mem_wa      = r_ev_idx;
                    mem_wd.last = rd_entry.last;
                    mem_wd.cnt  = 16'd0;
                    hw_en       = 1'b1;
                    hw_idx      = r_ev_idx;
                    hw_val      = slhw_pkg::HEALTH_TIMEOUT;
                    n_drop      = r_drop | (16'd1 << r_ev_idx);
                end
            end
            S_OUT: begin
                // hand over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ev_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= n_ev_vld;
        end
        r_idx    <= n_idx;
        r_now    <= n_now;
        r_walk   <= n_walk;
        r_ev_idx <= n_ev_idx;
        r_drop   <= n_drop;
        r_conn   <= n_conn;
    end

    // Channel store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    // Entry valid flags and registered read flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_mem_vld[mem_wa] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_vld <= r_mem_vld[mem_ra];
            end
        end
    end

    // Health flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_health[k] <= slhw_pkg::HEALTH_UNKNOWN;
            end
        end else if (hw_en) begin
            r_health[hw_idx] <= hw_val;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_conn <= r_conn;
            r_out_mask <= r_drop;
            r_out_hok  <= health_all;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_connected      = r_out_conn;
    assign o_timed_out_mask = r_out_mask;
    assign o_health_ok      = r_out_hok;

`ifndef ASSERT_OFF
    // An accepted command stalls the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after an accepted command");

    // An arrival result never reports drops, a tick never connects
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_connected && (o_timed_out_mask != 16'd0)))
        else $error("result reports both a connect and a drop");

    // A new result appears only out of the output state
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside the output state");

    // Store writes happen only in update or walk states
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_AEV || r_state == S_TWALK || r_state == S_TLAST))
        else $error("store written outside an update state");

    // Health code three never appears on channel zero
    a_health_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_health[0] != 2'd3)
        else $error("invalid health code");
`endif

endmodule

FILE: rtl/slhw_cmp_unit.sv
`timescale 1ns / 1ps
// Shared subtract-and-compare unit: flags (minuend - subtrahend) mod 2^32 > limit.
// Depends on slhw_pkg for the request struct.

module slhw_cmp_unit (
    input  slhw_pkg::t_cmp_req i_req,
    output logic               o_gt
);

    logic [31:0] diff;

    // Wrap-around difference, then compare against the limit
    assign diff = i_req.minuend - i_req.subtrahend;
    assign o_gt = (diff > i_req.limit);

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sensor link health watchdog.
// Depends on slhw_pkg and sensor_link_health_watchdog; a built-in predictor checks every result beat.

module tb;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_TICK    = 1'b1;
    localparam int   NCH         = 16;
    localparam int   QUIET_LIMIT = 5000;
    localparam int   MAX_REPORTS = 100;

    typedef struct packed {
        logic        connected;
        logic [15:0] dropped;
        logic        health_ok;
    } t_outcome;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_cmd       = 1'b0;
    logic [3:0]  i_channel   = 4'd0;
    logic [31:0] i_time_now  = 32'd0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = slhw_pkg::REG_TIMEOUT_US;
    logic [31:0] i_cfg_data  = 32'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_connected;
    logic [15:0] o_timed_out_mask;
    logic        o_health_ok;
    logic        o_cfg_ready;

    sensor_link_health_watchdog dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_channel        (i_channel),
        .i_time_now       (i_time_now),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_connected      (o_connected),
        .o_timed_out_mask (o_timed_out_mask),
        .o_health_ok      (o_health_ok),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: per-channel health, arrival count and last arrival time
    slhw_pkg::t_health chan_state [NCH];
    logic [15:0] arrivals     [NCH];
    logic [31:0] last_seen_us [NCH];
    logic [31:0] timeout_lim;
    logic [15:0] stream_need;
    logic [15:0] check_bits;
    logic [15:0] present_bits;

    t_outcome expected_results [$];

    int  errors        = 0;
    int  items_sent    = 0;
    int  ticks_sent    = 0;
    int  results_seen  = 0;
    int  connects_seen = 0;
    int  drops_seen    = 0;
    int  healthy_seen  = 0;
    int  quiet_cycles  = 0;
    int  stall_left    = 0;
    bit  gaps_on       = 1'b1;
    bit  stall_on      = 1'b1;

    function automatic void reset_health_state();
        timeout_lim  = slhw_pkg::TIMEOUT_US_RST;
        stream_need  = slhw_pkg::STREAM_COUNT_RST;
        check_bits   = slhw_pkg::CHECK_MASK_RST;
        present_bits = slhw_pkg::PRESENT_MASK_RST;
        for (int i = 0; i < NCH; i++) begin
            chan_state[i]   = slhw_pkg::HEALTH_UNKNOWN;
            arrivals[i]     = 16'd0;
            last_seen_us[i] = 32'd0;
        end
    endfunction

    // Advance the channel table by one command and return the result it should give
    function automatic t_outcome predict_step(input logic c, input logic [3:0] ch,
                                              input logic [31:0] t);
        t_outcome    res;
        logic [31:0] age;
        res = '0;
        if (c == CMD_ARRIVAL) begin
            last_seen_us[ch] = t;
            if (arrivals[ch] != 16'hFFFF)
                arrivals[ch] = arrivals[ch] + 16'd1;
            if (chan_state[ch] == slhw_pkg::HEALTH_TIMEOUT && arrivals[ch] > stream_need) begin
                chan_state[ch] = slhw_pkg::HEALTH_OK;
                res.connected  = 1'b1;
            end else if (chan_state[ch] == slhw_pkg::HEALTH_UNKNOWN) begin
                chan_state[ch] = slhw_pkg::HEALTH_TIMEOUT;
            end
        end else begin
            for (int i = 0; i < NCH; i++) begin
                age = t - last_seen_us[i];
                if (check_bits[i] && chan_state[i] == slhw_pkg::HEALTH_OK &&
                    age > timeout_lim) begin
                    chan_state[i]  = slhw_pkg::HEALTH_TIMEOUT;
                    arrivals[i]    = 16'd0;
                    res.dropped[i] = 1'b1;
                end
            end
        end
        res.health_ok = 1'b1;
        for (int i = 0; i < NCH; i++)
            if (present_bits[i] && chan_state[i] != slhw_pkg::HEALTH_OK)
                res.health_ok = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Send one command beat; an optional gap of idle cycles goes first
    task automatic send_item(input logic c, input logic [3:0] ch, input logic [31:0] t);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            i_cmd      <= 1'($urandom);
            i_channel  <= 4'($urandom);
            i_time_now <= $urandom;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= c;
        i_channel  <= ch;
        i_time_now <= t;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        expected_results.push_back(predict_step(c, ch, t));
        items_sent++;
        if (c == CMD_TICK)
            ticks_sent++;
    endtask

    // Drop valid and wait until every result beat has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        case (idx)
            slhw_pkg::REG_TIMEOUT_US:   timeout_lim  = val;
            slhw_pkg::REG_STREAM_COUNT: stream_need  = val[15:0];
            slhw_pkg::REG_CHECK_MASK:   check_bits   = val[15:0];
            slhw_pkg::REG_PRESENT_MASK: present_bits = val[15:0];
            default: ;
        endcase
    endtask

    // Write all four registers while the block is idle; upper bits of the
    // narrow registers carry junk that must be dropped
    task automatic apply_config(input logic [31:0] tmo, input logic [15:0] need,
                                input logic [15:0] chk, input logic [15:0] pres);
        drain_results();
        write_reg(slhw_pkg::REG_TIMEOUT_US, tmo);
        write_reg(slhw_pkg::REG_STREAM_COUNT, {16'($urandom), need});
        write_reg(slhw_pkg::REG_CHECK_MASK, {16'($urandom), chk});
        write_reg(slhw_pkg::REG_PRESENT_MASK, {16'($urandom), pres});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [3:0] pick_channel(input logic [15:0] m);
        logic [3:0] ch;
        do ch = 4'($urandom_range(0, NCH - 1)); while (!m[ch]);
        return ch;
    endfunction

    // Reset values: eleven arrivals bring a channel to ok, the age limit is inclusive
    task automatic test_reset_defaults();
        send_item(CMD_TICK, 4'd9, 32'd0);
        for (int k = 1; k <= 11; k++)
            send_item(CMD_ARRIVAL, 4'd3, 32'(k * 1000));
        send_item(CMD_TICK, 4'd0, 32'd211000);
        send_item(CMD_TICK, 4'd15, 32'd211001);
    endtask

    // Field extremes, wrap-around age, masked checks and the present set
    task automatic test_directed_edges();
        apply_config(32'd100, 16'd1, 16'hFFFF, 16'h8001);
        send_item(CMD_TICK, 4'd0, 32'd0);
        send_item(CMD_ARRIVAL, 4'd0, 32'hFFFF_FFF0);
        send_item(CMD_ARRIVAL, 4'd0, 32'hFFFF_FFF8);
        send_item(CMD_ARRIVAL, 4'd15, 32'd0);
        send_item(CMD_ARRIVAL, 4'd15, 32'd10);
        send_item(CMD_TICK, 4'd7, 32'h5C);
        send_item(CMD_TICK, 4'd7, 32'h5D);
        send_item(CMD_ARRIVAL, 4'd0, 32'h60);
        send_item(CMD_ARRIVAL, 4'd0, 32'h61);
        send_item(CMD_TICK, 4'd15, 32'hFFFF_FFFF);

        apply_config(32'hFFFF_FFFF, 16'd0, 16'h0000, 16'h0080);
        send_item(CMD_ARRIVAL, 4'd7, 32'd5);
        send_item(CMD_ARRIVAL, 4'd7, 32'd5);
        send_item(CMD_TICK, 4'd0, 32'd4);

        apply_config(32'd0, 16'd0, 16'hFFFF, 16'h0080);
        send_item(CMD_TICK, 4'd0, 32'd4);
        send_item(CMD_TICK, 4'd0, 32'd5);
        send_item(CMD_TICK, 4'd0, 32'd6);
    endtask

    // Random phases: arrivals mostly on a small set of live channels with time
    // moving forward, ticks at random, and a little noise on any channel
    task automatic test_random_traffic();
        logic [15:0] live;
        logic [31:0] now_us;
        logic [31:0] tmo;
        logic [31:0] span;
        logic [15:0] need;
        logic [15:0] chk;
        logic [15:0] pres;
        int          sel;
        for (int phase = 0; phase < 8; phase++) begin
            live = '0;
            repeat ($urandom_range(2, 6)) live[$urandom_range(0, NCH - 1)] = 1'b1;

            sel = $urandom_range(0, 4);
            tmo = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF :
                  (sel == 2) ? 32'($urandom_range(1, 50)) :
                  (sel == 3) ? 32'($urandom_range(51, 3000)) : $urandom;
            sel  = $urandom_range(0, 9);
            need = (sel < 2) ? 16'd0 : (sel < 6) ? 16'($urandom_range(1, 4)) :
                   (sel < 8) ? 16'($urandom_range(5, 12)) :
                   (sel == 8) ? 16'hFFFF : 16'($urandom);
            sel  = $urandom_range(0, 9);
            chk  = (sel < 6) ? 16'hFFFF : (sel < 8) ? 16'($urandom) :
                   (sel == 8) ? 16'h0000 : live;
            sel  = $urandom_range(0, 9);
            pres = (sel < 5) ? live : (sel < 7) ? 16'($urandom) :
                   (sel == 7) ? 16'h0000 : (sel == 8) ? 16'hFFFF : live & 16'($urandom);
            if (phase == 0) begin
                tmo  = 32'd0;
                need = 16'd0;
            end else if (phase == 1) begin
                tmo  = 32'hFFFF_FFFF;
                need = 16'hFFFF;
                pres = 16'hFFFF;
            end
            apply_config(tmo, need, chk, pres);
            gaps_on  = (phase % 3 != 2);
            stall_on = (phase % 4 != 3);

            now_us = $urandom;
            span   = (timeout_lim < 32'd4000) ? timeout_lim / 2 + 1 : 32'd1500;
            repeat (95) begin
                sel = $urandom_range(0, 99);
                if (sel < 20)
                    send_item(CMD_TICK, 4'($urandom), now_us);
                else if (sel < 24)
                    send_item(CMD_ARRIVAL, 4'($urandom), $urandom);
                else
                    send_item(CMD_ARRIVAL, pick_channel(live), now_us);
                if ($urandom_range(0, 19) == 0)
                    now_us = now_us + timeout_lim + 32'($urandom_range(0, 3));
                else
                    now_us = now_us + $urandom_range(0, span);
            end
        end
    endtask

    // Force one channel into timeout, then hold it there with the need at its
    // top value; a lower need lets the next arrival through
    task automatic test_need_ceiling();
        logic [3:0] ch;
        ch       = 4'($urandom_range(0, NCH - 1));
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        apply_config(32'd0, 16'hFFFF, 16'h0001 << ch, 16'h0001 << ch);
        send_item(CMD_ARRIVAL, ch, 32'd500);
        send_item(CMD_TICK, 4'($urandom), 32'd501);
        for (int k = 0; k < 30; k++)
            send_item(CMD_ARRIVAL, ch, 32'(600 + k));
        apply_config(32'd0, 16'd20, 16'h0001 << ch, 16'h0001 << ch);
        send_item(CMD_ARRIVAL, ch, 32'd1000);
        send_item(CMD_TICK, 4'($urandom), 32'd1000);
        send_item(CMD_TICK, 4'($urandom), 32'd1001);
        send_item(CMD_ARRIVAL, ch, 32'd1002);
    endtask

    // Output stall: random bursts of back-pressure while stall_on is set
    always @(posedge i_clk) begin
        if (!stall_on)
            stall_left = 0;
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
        i_out_stall <= (stall_left > 0);
    end

    // Check each result beat; inputs and outputs settle between edges, so the
    // handshake seen here is the one taken at the next rising edge
    always @(negedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (o_connected !== want.connected)
                    report_mismatch($sformatf("connected %b, want %b",
                                              o_connected, want.connected));
                if (o_timed_out_mask !== want.dropped)
                    report_mismatch($sformatf("timed_out_mask %h, want %h",
                                              o_timed_out_mask, want.dropped));
                if (o_health_ok !== want.health_ok)
                    report_mismatch($sformatf("health_ok %b, want %b",
                                              o_health_ok, want.health_ok));
                connects_seen += want.connected;
                drops_seen    += $countones(want.dropped);
                healthy_seen  += want.health_ok;
            end
        end
    end

    // Hang guard: end the run if no beat moves on any channel for too long
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        reset_health_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_edges();
        test_random_traffic();
        test_need_ceiling();

        drain_results();
        repeat (25) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Sent %0d commands (%0d ticks), checked %0d result beats",
                 items_sent, ticks_sent, results_seen);
        $display("Saw %0d connects, %0d channel timeouts, %0d healthy results, %0d mismatches",
                 connects_seen, drops_seen, healthy_seen, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
rtl/slhw_pkg.sv
rtl/slhw_cmp_unit.sv
rtl/sensor_link_health_watchdog.sv
verif/tb.sv
